[rtl/xpr_pkg.sv]
package xpr_pkg;

  localparam int PACKET_BYTES_DEFAULT = 128;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;

  localparam logic [23:0] CNT_MAX = 24'hFF_FFFF;
  localparam logic [23:0] IDLE_LIMIT_RESET = 24'd1000000;
  localparam logic [7:0] FIRST_SEQ_RESET = 8'h00;

  localparam logic CFG_FIRST_SEQ = 1'b0;
  localparam logic CFG_IDLE_LIMIT = 1'b1;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_ACK = 2'd1;
  localparam logic [1:0] OP_BYTE = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  typedef enum logic [1:0] {
    K_START,
    K_ACK,
    K_BYTE,
    K_TICK
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_SEQ,
    PH_CSEQ,
    PH_DATA,
    PH_SUM,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    EV_DATA = 3'd0,
    EV_GOOD = 3'd1,
    EV_BAD = 3'd2,
    EV_FINISH = 3'd3,
    EV_NOTRANS = 3'd4,
    EV_STATEERR = 3'd5,
    EV_CMD = 3'd6
  } ev_t;

  typedef struct packed {
    kind_t kind;
    logic [7:0] rx;
    logic is_soh;
    logic is_eot;
  } item_t;

  typedef struct packed {
    ev_t ev;
    logic [7:0] data_byte;
    logic [6:0] byte_index;
    logic [7:0] packet_seq;
    logic tx_valid;
    logic [7:0] tx_byte;
  } res_t;

  typedef struct packed {
    logic en;
    logic index;
    logic [23:0] data;
  } cfg_wr_t;

endpackage

[rtl/xmodem_packet_receiver.sv]
// XMODEM checksum receiver. Each input word is a command, a received byte or an idle tick, and
// the block takes one word per clock cycle while input stall is low. A word is classified on
// entry and placed in a two-entry queue; the receive state machine behind it handles one word
// per cycle unless output stall holds a result. Input stall rises only when the queue is full,
// which happens only while results are held back by output stall. Configuration writes are taken
// in any cycle and should be made while the block is idle.
module xmodem_packet_receiver
  import xpr_pkg::*;
#(
  parameter int PACKET_BYTES = PACKET_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [7:0]  data_byte,
  output logic [6:0]  byte_index,
  output logic [7:0]  packet_seq,
  output logic        tx_valid,
  output logic [7:0]  tx_byte
);

  item_t front_item;
  item_t q_item;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic in_accept;
  cfg_wr_t cfg;
  res_t res;

  assign cfg_ready = 1'b1;
  assign cfg.en = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data = cfg_data;

  assign in_stall = q_full;
  assign in_accept = in_valid && !q_full;

  xpr_front u_front (
    .opcode (opcode),
    .rx_byte(rx_byte),
    .item   (front_item)
  );

  xpr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (in_accept),
    .push_item(front_item),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .head     (q_item)
  );

  xpr_back #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .res      (res)
  );

  assign event_res = res.ev;
  assign data_byte = res.data_byte;
  assign byte_index = res.byte_index;
  assign packet_seq = res.packet_seq;
  assign tx_valid = res.tx_valid;
  assign tx_byte = res.tx_byte;

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_accept_reaches_queue: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> q_valid)
    else $error("accepted word missing from queue");

  a_tx_only_on_control: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tx_valid) |->
      (event_res == EV_BAD || event_res == EV_FINISH || event_res == EV_CMD))
    else $error("transmit request on an event that sends nothing");

  a_data_fields_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_DATA) |-> (!tx_valid && packet_seq == 8'd0))
    else $error("data event carries control fields");

endmodule

[rtl/xpr_front.sv]
module xpr_front
  import xpr_pkg::*;
(
  input  logic [1:0] opcode,
  input  logic [7:0] rx_byte,
  output item_t      item
);

  always_comb begin
    item = '0;
    item.rx = rx_byte;
    item.is_soh = (rx_byte == CH_SOH);
    item.is_eot = (rx_byte == CH_EOT);
    case (opcode)
      OP_START: item.kind = K_START;
      OP_ACK:   item.kind = K_ACK;
      OP_BYTE:  item.kind = K_BYTE;
      OP_TICK:  item.kind = K_TICK;
      default:  item.kind = K_TICK;
    endcase
  end

endmodule

[rtl/xpr_queue.sv]
module xpr_queue
  import xpr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  localparam int DEPTH = 2;

  item_t entries [DEPTH];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'(DEPTH));
  assign not_empty = (count != 2'd0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[rtl/xpr_back.sv]
module xpr_back
  import xpr_pkg::*;
#(
  parameter int PACKET_BYTES = PACKET_BYTES_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_stall,
  output res_t    res
);

  localparam int CW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;

  phase_t phase, phase_next;
  logic [7:0] expected_seq, expected_seq_next;
  logic header_error, header_error_next;
  logic [7:0] running_sum, running_sum_next;
  logic [CW-1:0] data_count, data_count_next;
  logic [23:0] idle_count, idle_count_next;
  logic [23:0] idle_limit, idle_limit_next;
  logic out_valid_next;
  res_t res_next;
  res_t r;
  logic emit;

  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      expected_seq <= FIRST_SEQ_RESET;
      header_error <= 1'b0;
      running_sum <= 8'd0;
      data_count <= '0;
      idle_count <= 24'd0;
      idle_limit <= IDLE_LIMIT_RESET;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      expected_seq <= expected_seq_next;
      header_error <= header_error_next;
      running_sum <= running_sum_next;
      data_count <= data_count_next;
      idle_count <= idle_count_next;
      idle_limit <= idle_limit_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  always_comb begin
    phase_next = phase;
    expected_seq_next = expected_seq;
    header_error_next = header_error;
    running_sum_next = running_sum;
    data_count_next = data_count;
    idle_count_next = idle_count;
    idle_limit_next = idle_limit;
    r = '0;
    r.ev = EV_DATA;
    emit = 1'b0;

    if (q_pop) begin
      case (q_item.kind)
        K_START, K_ACK: begin
          phase_next = PH_WAIT;
          idle_count_next = 24'd0;
          emit = 1'b1;
          r.ev = EV_CMD;
          r.tx_valid = 1'b1;
          r.tx_byte = (q_item.kind == K_START) ? CH_NAK : CH_ACK;
        end
        default: begin
          if (phase == PH_IDLE) begin
            emit = 1'b1;
            r.ev = EV_STATEERR;
          end else if (phase == PH_DONE) begin
            emit = 1'b0;
          end else if (q_item.kind == K_TICK) begin
            if (idle_count > idle_limit) begin
              idle_count_next = 24'd0;
              emit = 1'b1;
              r.ev = EV_NOTRANS;
            end else if (idle_count != CNT_MAX) begin
              idle_count_next = idle_count + 24'd1;
            end
          end else begin
            case (phase)
              PH_WAIT: begin
                if (q_item.is_soh) begin
                  phase_next = PH_SEQ;
                  header_error_next = 1'b0;
                end else if (q_item.is_eot) begin
                  phase_next = PH_IDLE;
                  idle_count_next = 24'd0;
                  emit = 1'b1;
                  r.ev = EV_FINISH;
                  r.tx_valid = 1'b1;
                  r.tx_byte = CH_ACK;
                end
              end
              PH_SEQ: begin
                if (q_item.rx != expected_seq) begin
                  header_error_next = 1'b1;
                end
                phase_next = PH_CSEQ;
              end
              PH_CSEQ: begin
                if (q_item.rx != ~expected_seq) begin
                  header_error_next = 1'b1;
                end
                running_sum_next = 8'd0;
                data_count_next = '0;
                phase_next = PH_DATA;
              end
              PH_DATA: begin
                running_sum_next = running_sum + q_item.rx;
                data_count_next = data_count + CW'(1);
                if (data_count == CW'(PACKET_BYTES - 1)) begin
                  phase_next = PH_SUM;
                end
                emit = 1'b1;
                r.ev = EV_DATA;
                r.data_byte = q_item.rx;
                r.byte_index = 7'(data_count);
              end
              PH_SUM: begin
                emit = 1'b1;
                if (running_sum == q_item.rx && !header_error) begin
                  expected_seq_next = expected_seq + 8'd1;
                  phase_next = PH_DONE;
                  idle_count_next = 24'd0;
                  r.ev = EV_GOOD;
                  r.packet_seq = expected_seq;
                end else begin
                  phase_next = PH_WAIT;
                  r.ev = EV_BAD;
                  r.tx_valid = 1'b1;
                  r.tx_byte = CH_NAK;
                end
              end
              default: begin
                phase_next = PH_IDLE;
              end
            endcase
          end
        end
      endcase
    end

    if (cfg.en) begin
      if (cfg.index == CFG_FIRST_SEQ) begin
        expected_seq_next = cfg.data[7:0];
      end else begin
        idle_limit_next = cfg.data;
      end
    end

    out_valid_next = out_valid && out_stall;
    res_next = res;
    if (q_pop && emit) begin
      out_valid_next = 1'b1;
      res_next = r;
    end
  end

endmodule

[test/xmodem_packet_receiver_test.sv]
module xmodem_packet_receiver_test;
  import xpr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PKT = 128;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 357;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [23:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [1:0] opcode;
  logic [7:0] rx_byte;
  logic out_valid;
  logic out_stall;
  logic [2:0] event_res;
  logic [7:0] data_byte;
  logic [6:0] byte_index;
  logic [7:0] packet_seq;
  logic tx_valid;
  logic [7:0] tx_byte;

  xmodem_packet_receiver #(
    .PACKET_BYTES(PKT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_res(event_res),
    .data_byte(data_byte),
    .byte_index(byte_index),
    .packet_seq(packet_seq),
    .tx_valid(tx_valid),
    .tx_byte(tx_byte)
  );

  always #5ns clk = ~clk;

  // Receiver state as it should be after every accepted word.
  phase_t rx_phase;
  logic [7:0] seq_exp;
  logic [7:0] sum_acc;
  logic [7:0] byte_count;
  logic hdr_err;
  logic [23:0] idle_cnt;
  logic [23:0] idle_lim;

  res_t pending_results[$];

  int cycle_count = 0;
  int words_sent = 0;
  int effective_words = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int good_packets = 0;
  int bad_packets = 0;
  int no_transfer_reports = 0;
  bit bursty = 1'b1;
  int burst_left = 0;
  bit spoil_header = 1'b0;
  int stall_pct = 0;
  int stall_run = 0;

  function automatic void reset_receiver_model();
    idle_lim = IDLE_LIMIT_RESET;
    rx_phase = PH_IDLE;
    seq_exp = FIRST_SEQ_RESET;
    hdr_err = 1'b0;
    sum_acc = '0;
    byte_count = '0;
    idle_cnt = '0;
  endfunction

  function automatic bit predict_receiver(input logic [1:0] op, input logic [7:0] b,
                                          output res_t r);
    r = '0;
    if (op == OP_START || op == OP_ACK) begin
      rx_phase = PH_WAIT;
      idle_cnt = '0;
      r.ev = EV_CMD;
      r.tx_valid = 1'b1;
      r.tx_byte = (op == OP_START) ? CH_NAK : CH_ACK;
      return 1'b1;
    end
    if (rx_phase == PH_IDLE) begin
      r.ev = EV_STATEERR;
      return 1'b1;
    end
    if (rx_phase == PH_DONE) return 1'b0;
    if (op == OP_TICK) begin
      if (idle_cnt > idle_lim) begin
        idle_cnt = '0;
        r.ev = EV_NOTRANS;
        return 1'b1;
      end
      if (idle_cnt != CNT_MAX) idle_cnt = idle_cnt + 1'b1;
      return 1'b0;
    end
    case (rx_phase)
      PH_WAIT: begin
        if (b == CH_SOH) begin
          rx_phase = PH_SEQ;
          hdr_err = 1'b0;
        end else if (b == CH_EOT) begin
          rx_phase = PH_IDLE;
          idle_cnt = '0;
          r.ev = EV_FINISH;
          r.tx_valid = 1'b1;
          r.tx_byte = CH_ACK;
          return 1'b1;
        end
        return 1'b0;
      end
      PH_SEQ: begin
        if (b != seq_exp) hdr_err = 1'b1;
        rx_phase = PH_CSEQ;
        return 1'b0;
      end
      PH_CSEQ: begin
        if (b != ~seq_exp) hdr_err = 1'b1;
        sum_acc = '0;
        byte_count = '0;
        rx_phase = PH_DATA;
        return 1'b0;
      end
      PH_DATA: begin
        r.ev = EV_DATA;
        r.data_byte = b;
        r.byte_index = byte_count[6:0];
        sum_acc = sum_acc + b;
        byte_count = byte_count + 1'b1;
        if (byte_count >= PKT) rx_phase = PH_SUM;
        return 1'b1;
      end
      PH_SUM: begin
        if (sum_acc == b && !hdr_err) begin
          r.ev = EV_GOOD;
          r.packet_seq = seq_exp;
          seq_exp = seq_exp + 1'b1;
          rx_phase = PH_DONE;
          idle_cnt = '0;
          return 1'b1;
        end
        rx_phase = PH_WAIT;
        r.ev = EV_BAD;
        r.tx_valid = 1'b1;
        r.tx_byte = CH_NAK;
        return 1'b1;
      end
      default: begin
        rx_phase = PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  // Mostly well-formed transfers driven by where the receiver stands, with some noise.
  function automatic void choose_word(output logic [1:0] op, output logic [7:0] b);
    int pick;
    pick = $urandom_range(0, 99);
    op = OP_BYTE;
    b = 8'($urandom);
    if (pick < 3) begin
      op = 2'($urandom_range(0, 3));
      return;
    end
    case (rx_phase)
      PH_IDLE: op = (pick < 60) ? OP_START : ((pick < 88) ? OP_ACK : OP_TICK);
      PH_WAIT: begin
        if (pick < 70) b = CH_SOH;
        else if (pick < 76) b = CH_EOT;
        else if (pick < 88) op = OP_TICK;
      end
      PH_SEQ: begin
        if (pick < 88 && !spoil_header) b = seq_exp;
        spoil_header = 1'b0;
      end
      PH_CSEQ: if (pick < 90) b = ~seq_exp;
      PH_DATA: begin
        if (pick < 7) op = OP_TICK;
        else if (pick == 7) op = OP_START;
      end
      PH_SUM: if (hdr_err || pick < 85) b = sum_acc;
      PH_DONE: begin
        if (pick < 80) op = OP_ACK;
        else if (pick < 85) op = OP_START;
        else if (pick < 93) op = OP_TICK;
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [7:0] b);
    res_t r;
    bit has;
    phase_t ph0;
    logic [23:0] ic0;
    in_valid <= 1'b1;
    opcode <= op;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    ph0 = rx_phase;
    ic0 = idle_cnt;
    has = predict_receiver(op, b, r);
    words_sent++;
    if (has) begin
      pending_results.push_back(r);
      if (r.ev == EV_GOOD) good_packets++;
      if (r.ev == EV_BAD) bad_packets++;
      if (r.ev == EV_NOTRANS) no_transfer_reports++;
    end
    if (has || ph0 != rx_phase || ic0 != idle_cnt) effective_words++;
    if (bursty) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic settle();
    wait_drained();
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FIRST_SEQ) begin
      seq_exp = value[7:0];
    end else begin
      idle_lim = value;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_idle_state_errors();
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_TICK, 8'h00);
  endtask

  task automatic test_command_flow();
    send_word(OP_START, 8'h00);
    send_word(OP_BYTE, 8'hAA);
    send_word(OP_TICK, 8'h00);
    send_word(OP_ACK, 8'hFF);
    send_word(OP_BYTE, CH_EOT);
    send_word(OP_BYTE, 8'h55);
  endtask

  task automatic test_idle_limit();
    settle();
    write_register(CFG_IDLE_LIMIT, 24'd0);
    send_word(OP_START, 8'h00);
    send_word(OP_TICK, 8'h00);
    send_word(OP_TICK, 8'hFF);
    send_word(OP_BYTE, CH_EOT);
  endtask

  task automatic test_interrupted_packet();
    settle();
    write_register(CFG_FIRST_SEQ, 24'hFFFFFF);
    send_word(OP_START, 8'h00);
    send_word(OP_BYTE, CH_SOH);
    send_word(OP_ACK, 8'h00);
    send_word(OP_BYTE, CH_SOH);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_START, 8'h00);
    send_word(OP_TICK, 8'h00);
  endtask

  task automatic test_random_transfers(input logic [23:0] seq_word, input logic [23:0] limit);
    int goal;
    int n;
    logic [1:0] op;
    logic [7:0] b;
    settle();
    write_register(CFG_FIRST_SEQ, seq_word);
    write_register(CFG_IDLE_LIMIT, limit);
    spoil_header = 1'b1;
    goal = effective_words + RANDOM_WORDS;
    n = 0;
    while (effective_words < goal) begin
      choose_word(op, b);
      send_word(op, b);
      n++;
      if ($urandom_range(0, 99) == 0) bursty = !bursty;
      if (n == 40 || $urandom_range(0, 299) == 0) wait_drained();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 20;
          3: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        stall_run = $urandom_range(16, 160);
      end
      stall_run--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: ev=%0d data=%02h idx=%0d seq=%02h tx=%0d/%02h",
                   event_res, data_byte, byte_index, packet_seq, tx_valid, tx_byte);
      end else begin
        want = pending_results.pop_front();
        if (event_res !== want.ev || data_byte !== want.data_byte ||
            byte_index !== want.byte_index || packet_seq !== want.packet_seq ||
            tx_valid !== want.tx_valid || tx_byte !== want.tx_byte) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: expected ev=%0d data=%02h idx=%0d seq=%02h tx=%0d/%02h, %s",
                     results_checked, want.ev, want.data_byte, want.byte_index,
                     want.packet_seq, want.tx_valid, want.tx_byte,
                     $sformatf("got ev=%0d data=%02h idx=%0d seq=%02h tx=%0d/%02h",
                               event_res, data_byte, byte_index, packet_seq,
                               tx_valid, tx_byte));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("xmodem_packet_receiver: mismatch");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_START;
    rx_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = CFG_FIRST_SEQ;
    cfg_data = '0;
    reset_receiver_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_idle_state_errors();
    test_command_flow();
    test_idle_limit();
    test_interrupted_packet();
    test_random_transfers({16'($urandom), 8'h00}, 24'd16777214);
    test_random_transfers({16'($urandom), 8'hFF}, 24'd0);
    test_random_transfers(24'($urandom), 24'($urandom_range(1, 40)));
    test_random_transfers(24'($urandom), 24'($urandom_range(0, 16777214)));

    settle();
    $display("Sent %0d words (%0d with effect) and checked %0d results.",
             words_sent, effective_words, results_checked);
    $display("Packets judged good: %0d, bad: %0d; no-transfer reports: %0d.",
             good_packets, bad_packets, no_transfer_reports);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("xmodem_packet_receiver: match");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count,
               pending_results.size());
      $display("xmodem_packet_receiver: mismatch");
    end
    $finish;
  end

endmodule
